>>> rtl/sol_pkg.sv
package sol_pkg;

    localparam int MAX_ITEMS = 256;
    localparam int POS_W     = $clog2(MAX_ITEMS);
    localparam int ID_W      = 9;
    localparam int LEN_W     = 9;
    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 9;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LENGTH = 1'd1;

    localparam logic [1:0] POL_MTF       = 2'd0;
    localparam logic [1:0] POL_TRANSPOSE = 2'd1;
    localparam logic [1:0] POL_COUNT     = 2'd2;

    localparam logic       MODE_LOOKUP = 1'b0;
    localparam logic       MODE_REINIT = 1'b1;

endpackage

>>> rtl/sol_req_if.sv
interface sol_req_if
    import sol_pkg::*;
;
    logic            valid;
    logic            ready;
    logic            mode;
    logic [ID_W-1:0] requested_id;

    modport source (output valid, output mode, output requested_id, input ready);
    modport sink   (input valid, input mode, input requested_id, output ready);
endinterface

>>> rtl/sol_rsp_if.sv
interface sol_rsp_if
    import sol_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] cost;
    logic             found;

    modport source (output valid, output cost, output found, input ready);
    modport sink   (input valid, input cost, input found, output ready);
endinterface

>>> rtl/self_organizing_list_core.sv
// lookup: a linear search of the order memory from position 0; a hit is then moved
//   by the policy: move-to-front rotates it to the front, transpose swaps it with its
//   predecessor, frequency count bumps its count and rescans to reinsert it
// miss: the search reads every active entry; reinitialize: a sweep of both memories
// throughput: one item at a time, bounded by the single read port of the order memory
// reset: a clearing pass writes identity order and zero counts; no item is taken
//   until it ends, configuration writes are taken at once
module self_organizing_list_core
    import sol_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    sol_req_if.sink              req,
    sol_rsp_if.source            rsp
);

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_SEARCH = 4'd2;
    localparam logic [3:0] ST_TR1    = 4'd3;
    localparam logic [3:0] ST_TR2    = 4'd4;
    localparam logic [3:0] ST_CRD    = 4'd5;
    localparam logic [3:0] ST_CWR    = 4'd6;
    localparam logic [3:0] ST_QSCAN  = 4'd7;
    localparam logic [3:0] ST_ROTR   = 4'd8;
    localparam logic [3:0] ST_ROTL   = 4'd9;
    localparam logic [3:0] ST_WRID   = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;

    logic [ID_W-1:0]  ord_mem [MAX_ITEMS];
    logic [CNT_W-1:0] cnt_mem [MAX_ITEMS];
    logic [ID_W-1:0]  ord_rdata_reg;
    logic [CNT_W-1:0] cnt_rdata_reg;

    logic             ord_we, ord_re, cnt_we, cnt_re;
    logic [POS_W-1:0] ord_waddr, ord_raddr, cnt_waddr, cnt_raddr;
    logic [ID_W-1:0]  ord_wdata;
    logic [CNT_W-1:0] cnt_wdata;

    logic [3:0]       state_reg, state_next;
    logic [LEN_W-1:0] walk_reg, walk_next;
    logic [POS_W-1:0] lim_reg, lim_next;
    logic             rv_reg, rv_next, cv_reg, cv_next;
    logic [POS_W-1:0] pos_d_reg, pos_d_next, cpos_reg, cpos_next;
    logic [ID_W-1:0]  want_reg, want_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [1:0]       pol_reg, pol_next;
    logic [POS_W-1:0] p_reg, p_next;
    logic [ID_W-1:0]  prev_reg, prev_next, carry_reg, carry_next;
    logic [CNT_W-1:0] c_reg, c_next;
    logic [LEN_W-1:0] res_cost_reg, res_cost_next;
    logic             res_found_reg, res_found_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    logic [LEN_W-1:0] cost_reg, cost_next;
    logic             found_reg, found_next;
    logic [1:0]       policy_reg, policy_next;
    logic [CFG_W-1:0] alen_reg, alen_next;

    logic             issue;
    logic [POS_W-1:0] last;
    logic [LEN_W-1:0] eff_len;
    logic [CNT_W-1:0] inc_cnt;
    logic [ID_W-1:0]  want_m1;
    logic [ID_W-1:0]  rd_m1;
    logic [POS_W-1:0] q_pos;
    logic             q_hit;

    assign last    = POS_W'(len_reg - LEN_W'(1));
    assign issue   = (walk_reg <= {1'b0, lim_reg});
    assign inc_cnt = (cnt_rdata_reg == {CNT_W{1'b1}}) ? cnt_rdata_reg
                                                      : cnt_rdata_reg + CNT_W'(1);
    assign want_m1 = want_reg - ID_W'(1);
    assign rd_m1   = ord_rdata_reg - ID_W'(1);

    always_comb
    begin
        if (alen_reg == '0)
            eff_len = LEN_W'(1);
        else if (alen_reg > CFG_W'(MAX_ITEMS))
            eff_len = LEN_W'(MAX_ITEMS);
        else
            eff_len = alen_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[ord_waddr] <= ord_wdata;
        if (ord_re)
            ord_rdata_reg <= ord_mem[ord_raddr];
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cnt_re)
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
    end

    // qscan decision from the count pipeline
    always_comb
    begin
        q_hit = 1'b0;
        q_pos = last;
        if (cv_reg)
        begin
            if (cpos_reg != p_reg && cnt_rdata_reg <= c_reg)
            begin
                q_hit = 1'b1;
                q_pos = (cpos_reg < p_reg) ? cpos_reg : cpos_reg - POS_W'(1);
            end
            else if (cpos_reg == last)
            begin
                q_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        walk_next      = walk_reg;
        lim_next       = lim_reg;
        rv_next        = 1'b0;
        pos_d_next     = pos_d_reg;
        cv_next        = 1'b0;
        cpos_next      = cpos_reg;
        want_next      = want_reg;
        len_next       = len_reg;
        pol_next       = pol_reg;
        p_next         = p_reg;
        prev_next      = prev_reg;
        carry_next     = carry_reg;
        c_next         = c_reg;
        res_cost_next  = res_cost_reg;
        res_found_next = res_found_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        cost_next      = cost_reg;
        found_next     = found_reg;
        policy_next    = policy_reg;
        alen_next      = alen_reg;

        ord_we    = 1'b0;
        ord_waddr = walk_reg[POS_W-1:0];
        ord_wdata = want_reg;
        ord_re    = 1'b0;
        ord_raddr = walk_reg[POS_W-1:0];
        cnt_we    = 1'b0;
        cnt_waddr = walk_reg[POS_W-1:0];
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = rd_m1[POS_W-1:0];

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POLICY:        policy_next = cfg_data[1:0];
                REG_ACTIVE_LENGTH: alen_next   = cfg_data;
                default:           ;
            endcase
        end

        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;

        // shared read walk over the order memory
        if (state_reg == ST_SEARCH || state_reg == ST_QSCAN ||
            state_reg == ST_ROTR || state_reg == ST_ROTL)
        begin
            ord_re     = issue;
            walk_next  = walk_reg + LEN_W'(1);
            rv_next    = issue;
            pos_d_next = walk_reg[POS_W-1:0];
        end

        unique case (state_reg)
            ST_INIT:
            begin
                ord_we    = 1'b1;
                ord_wdata = ID_W'(walk_reg) + ID_W'(1);
                cnt_we    = 1'b1;
                walk_next = walk_reg + LEN_W'(1);
                if (walk_reg[POS_W-1:0] == POS_W'(MAX_ITEMS - 1))
                    state_next = pend_reg ? ST_DONE : ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    want_next = req.requested_id;
                    len_next  = eff_len;
                    pol_next  = policy_reg;
                    walk_next = '0;
                    if (req.mode == MODE_REINIT)
                    begin
                        res_cost_next  = '0;
                        res_found_next = 1'b0;
                        pend_next      = 1'b1;
                        state_next     = ST_INIT;
                    end
                    else
                    begin
                        lim_next   = POS_W'(eff_len - LEN_W'(1));
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (rv_reg)
                begin
                    if (ord_rdata_reg == want_reg)
                    begin
                        p_next         = pos_d_reg;
                        res_cost_next  = LEN_W'(pos_d_reg) + LEN_W'(1);
                        res_found_next = 1'b1;
                        rv_next        = 1'b0;
                        walk_next      = '0;
                        carry_next     = want_reg;
                        lim_next       = pos_d_reg;
                        state_next     = ST_DONE;
                        unique case (pol_reg)
                            POL_MTF:
                                if (pos_d_reg != '0)
                                    state_next = ST_ROTR;
                            POL_TRANSPOSE:
                                if (pos_d_reg != '0)
                                    state_next = ST_TR1;
                            POL_COUNT:
                                state_next = ST_CRD;
                            default:
                                state_next = ST_DONE;
                        endcase
                    end
                    else
                    begin
                        prev_next = ord_rdata_reg;
                        if (pos_d_reg == last)
                        begin
                            res_cost_next  = len_reg;
                            res_found_next = 1'b0;
                            rv_next        = 1'b0;
                            state_next     = ST_DONE;
                        end
                    end
                end
            end
            ST_TR1:
            begin
                ord_we     = 1'b1;
                ord_waddr  = p_reg - POS_W'(1);
                ord_wdata  = want_reg;
                state_next = ST_TR2;
            end
            ST_TR2:
            begin
                ord_we     = 1'b1;
                ord_waddr  = p_reg;
                ord_wdata  = prev_reg;
                state_next = ST_DONE;
            end
            ST_CRD:
            begin
                cnt_re     = 1'b1;
                cnt_raddr  = want_m1[POS_W-1:0];
                state_next = ST_CWR;
            end
            ST_CWR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = want_m1[POS_W-1:0];
                cnt_wdata = inc_cnt;
                c_next    = inc_cnt;
                walk_next = '0;
                lim_next  = last;
                if (p_reg == '0)
                    state_next = ST_DONE;
                else
                    state_next = ST_QSCAN;
            end
            ST_QSCAN:
            begin
                // the registered order read addresses the count read
                cnt_re    = rv_reg;
                cv_next   = rv_reg;
                cpos_next = pos_d_reg;
                if (q_hit)
                begin
                    rv_next    = 1'b0;
                    cv_next    = 1'b0;
                    carry_next = want_reg;
                    if (q_pos < p_reg)
                    begin
                        walk_next  = LEN_W'(q_pos);
                        lim_next   = p_reg;
                        state_next = ST_ROTR;
                    end
                    else if (q_pos > p_reg)
                    begin
                        walk_next  = LEN_W'(p_reg) + LEN_W'(1);
                        lim_next   = q_pos;
                        state_next = ST_ROTL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ROTR:
            begin
                if (rv_reg)
                begin
                    ord_we     = 1'b1;
                    ord_waddr  = pos_d_reg;
                    ord_wdata  = carry_reg;
                    carry_next = ord_rdata_reg;
                    if (pos_d_reg == lim_reg)
                    begin
                        rv_next    = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ROTL:
            begin
                if (rv_reg)
                begin
                    ord_we    = 1'b1;
                    ord_waddr = pos_d_reg - POS_W'(1);
                    ord_wdata = ord_rdata_reg;
                    if (pos_d_reg == lim_reg)
                    begin
                        rv_next    = 1'b0;
                        state_next = ST_WRID;
                    end
                end
            end
            ST_WRID:
            begin
                ord_we     = 1'b1;
                ord_waddr  = lim_reg;
                ord_wdata  = want_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    cost_next      = res_cost_reg;
                    found_next     = res_found_reg;
                    pend_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            walk_reg      <= '0;
            rv_reg        <= 1'b0;
            cv_reg        <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            policy_reg    <= POL_MTF;
            alen_reg      <= CFG_W'(MAX_ITEMS);
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            rv_reg        <= rv_next;
            cv_reg        <= cv_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            policy_reg    <= policy_next;
            alen_reg      <= alen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg       <= lim_next;
        pos_d_reg     <= pos_d_next;
        cpos_reg      <= cpos_next;
        want_reg      <= want_next;
        len_reg       <= len_next;
        pol_reg       <= pol_next;
        p_reg         <= p_next;
        prev_reg      <= prev_next;
        carry_reg     <= carry_next;
        c_reg         <= c_next;
        res_cost_reg  <= res_cost_next;
        res_found_reg <= res_found_next;
        cost_reg      <= cost_next;
        found_reg     <= found_next;
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.cost  = cost_reg;
    assign rsp.found = found_reg;

endmodule

>>> rtl/sol_checker.sv
module sol_checker
    import sol_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [LEN_W-1:0] rsp_cost,
    input logic             rsp_found
);

    // a hit reports a position inside the list
    a_hit_cost: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_found |-> rsp_cost != '0 && rsp_cost <= LEN_W'(MAX_ITEMS))
        else $error("hit with cost outside the list");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cost) && $stable(rsp_found))
        else $error("result dropped or changed while stalled");

    // clearing pass runs right after reset
    a_init_busy: assert property (@(posedge clk)
        $rose(rst_n) |-> !req_ready)
        else $error("item taken during clearing pass");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item taken before the first finished");

endmodule

bind self_organizing_list_core sol_checker u_sol_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_cost  (rsp.cost),
    .rsp_found (rsp.found)
);
